// ===== rtl/core/clock_request_table_defines.svh =====
// ---------------------------------------------------------------------------
// Clock request table assertion macros
// Concurrent assertion helpers, empty when the code is built for synthesis.
// ---------------------------------------------------------------------------
`ifndef CLOCK_REQUEST_TABLE_DEFINES_SVH
`define CLOCK_REQUEST_TABLE_DEFINES_SVH
`ifndef SYNTHESIS
`define CRT_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("clock request table assertion failed");
`define CRT_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("clock request table assertion failed");
`else
`define CRT_ASSERT(lbl, clk, rst_n, prop)
`define CRT_ASSERT_NR(lbl, clk, prop)
`endif
`endif

// ===== rtl/core/crt_pkg.sv =====
// ---------------------------------------------------------------------------
// Clock request table package
// Shared widths, codes, configuration defaults and beat types.
// ---------------------------------------------------------------------------
package crt_pkg;

  localparam int TABLE_DEPTH_DEF = 16;
  localparam int FREQ_W          = 10;
  localparam int TAG_W           = 4;
  localparam int NUM_TAGS        = 16;
  localparam int CFG_IDX_W       = 3;

  localparam logic [FREQ_W-1:0] FLOOR_CPU_RST = 10'd222;
  localparam logic [FREQ_W-1:0] FLOOR_BUS_RST = 10'd111;
  localparam logic [FREQ_W-1:0] HOT_CPU_RST   = 10'd266;
  localparam logic [FREQ_W-1:0] HOT_BUS_RST   = 10'd133;
  localparam logic [FREQ_W-1:0] MUSIC_CPU_RST = 10'd333;
  localparam logic [FREQ_W-1:0] MUSIC_BUS_RST = 10'd166;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FLOOR_CPU = 3'd0,
    CFG_FLOOR_BUS = 3'd1,
    CFG_HOT_CPU   = 3'd2,
    CFG_HOT_BUS   = 3'd3,
    CFG_MUSIC_CPU = 3'd4,
    CFG_MUSIC_BUS = 3'd5
  } crt_cfg_idx_e;

  typedef enum logic [1:0] {
    CMD_ENTER  = 2'd0,
    CMD_HOT    = 2'd1,
    CMD_LEAVE  = 2'd2,
    CMD_RECOMP = 2'd3
  } crt_cmd_e;

  typedef struct packed {
    logic [FREQ_W-1:0] floor_cpu;
    logic [FREQ_W-1:0] floor_bus;
    logic [FREQ_W-1:0] hot_cpu;
    logic [FREQ_W-1:0] hot_bus;
    logic [FREQ_W-1:0] music_cpu;
    logic [FREQ_W-1:0] music_bus;
  } crt_cfg_t;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [FREQ_W-1:0] cpu;
    logic [FREQ_W-1:0] bus;
  } crt_entry_t;

  typedef struct packed {
    crt_cmd_e          cmd;
    logic [FREQ_W-1:0] req_cpu;
    logic [FREQ_W-1:0] req_bus;
    logic [TAG_W-1:0]  leave_id;
    logic              music_playing;
  } crt_in_t;

  typedef struct packed {
    logic              status;
    logic [TAG_W-1:0]  new_id;
    logic [FREQ_W-1:0] cpu_out;
    logic [FREQ_W-1:0] bus_out;
    logic              clock_changed;
  } crt_out_t;

endpackage

// ===== rtl/core/crt_cfg.sv =====
// ---------------------------------------------------------------------------
// Clock request table configuration registers
// Floors and enter-hot presets, written through a plain write port.
// ---------------------------------------------------------------------------
module crt_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [crt_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [crt_pkg::FREQ_W-1:0]     cfg_data_i,
  output crt_pkg::crt_cfg_t              cfg_o
);

  crt_pkg::crt_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        crt_pkg::CFG_FLOOR_CPU: cfg_d.floor_cpu = cfg_data_i;
        crt_pkg::CFG_FLOOR_BUS: cfg_d.floor_bus = cfg_data_i;
        crt_pkg::CFG_HOT_CPU:   cfg_d.hot_cpu   = cfg_data_i;
        crt_pkg::CFG_HOT_BUS:   cfg_d.hot_bus   = cfg_data_i;
        crt_pkg::CFG_MUSIC_CPU: cfg_d.music_cpu = cfg_data_i;
        crt_pkg::CFG_MUSIC_BUS: cfg_d.music_bus = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.floor_cpu <= crt_pkg::FLOOR_CPU_RST;
      cfg_q.floor_bus <= crt_pkg::FLOOR_BUS_RST;
      cfg_q.hot_cpu   <= crt_pkg::HOT_CPU_RST;
      cfg_q.hot_bus   <= crt_pkg::HOT_BUS_RST;
      cfg_q.music_cpu <= crt_pkg::MUSIC_CPU_RST;
      cfg_q.music_bus <= crt_pkg::MUSIC_BUS_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/core/crt_mem.sv =====
// ---------------------------------------------------------------------------
// Clock request table entry store
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module crt_mem #(
  parameter int TABLE_DEPTH = crt_pkg::TABLE_DEPTH_DEF,
  parameter int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [IDX_W-1:0]    waddr_i,
  input  crt_pkg::crt_entry_t wdata_i,
  input  logic                re_i,
  input  logic [IDX_W-1:0]    raddr_i,
  output crt_pkg::crt_entry_t rdata_o
);

  crt_pkg::crt_entry_t mem_q [TABLE_DEPTH];
  crt_pkg::crt_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/clock_request_table.sv =====
// ---------------------------------------------------------------------------
// Clock request table
// Ordered table of cpu/bus clock requests with id allocation, removal and
// selection of the winning pair, raised to the configured floors.
// ---------------------------------------------------------------------------
// An enter collects the used ids, appends the entry under the smallest free id
// and rescans for the winner; a leave looks up the id, shifts the entries behind
// it down if found and rescans; a recompute only rescans; an enter into a full
// table skips to the result. One command at a time: busy is high until the result beat.
// The result beat stands for one cycle on done_o; the receiver cannot stall it.
// Reset empties the table, zeroes the clocks and loads the default presets.
// ---------------------------------------------------------------------------
`include "clock_request_table_defines.svh"

module clock_request_table #(
  parameter int TABLE_DEPTH = crt_pkg::TABLE_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  crt_pkg::crt_in_t              req_i,
  output logic                          done_o,
  output crt_pkg::crt_out_t             res_o,
  input  logic                          cfg_we_i,
  input  logic [crt_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [crt_pkg::FREQ_W-1:0]    cfg_data_i
);

  localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int FREQ_W = crt_pkg::FREQ_W;
  localparam int TAG_W  = crt_pkg::TAG_W;
  localparam int NT     = crt_pkg::NUM_TAGS;
  localparam int SUM_W  = FREQ_W + 1;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCAN  = 6'b000010,
    S_FREE  = 6'b000100,
    S_SHRD  = 6'b001000,
    S_SHWR  = 6'b010000,
    S_APPLY = 6'b100000
  } state_e;

  typedef enum logic [1:0] {
    PH_USED = 2'd0,
    PH_FIND = 2'd1,
    PH_MAX  = 2'd2
  } phase_e;

  crt_pkg::crt_cfg_t cfg;

  crt_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  logic                mem_we, mem_re;
  logic [IDX_W-1:0]    mem_waddr, mem_raddr;
  crt_pkg::crt_entry_t mem_wdata, mem_rdata;

  crt_mem #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .IDX_W       (IDX_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // control state
  state_e              state_q, state_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [FREQ_W-1:0]   cur_cpu_q, cur_cpu_d, cur_bus_q, cur_bus_d;
  logic                done_q, done_d;
  logic                pv_q, pv_d;

  // per-command working registers
  phase_e              phase_q, phase_d;
  logic [FREQ_W-1:0]   rcpu_q, rcpu_d, rbus_q, rbus_d;
  logic [TAG_W-1:0]    lid_q, lid_d;
  logic [CNT_W-1:0]    ptr_q, ptr_d;
  logic [IDX_W-1:0]    pidx_q, pidx_d;
  logic [NT-1:0]       used_q, used_d;
  logic [TAG_W-1:0]    idc_q, idc_d;
  logic                found_q, found_d;
  logic [IDX_W-1:0]    fidx_q, fidx_d;
  logic                any_q, any_d;
  logic [SUM_W-1:0]    bsum_q, bsum_d;
  logic [FREQ_W-1:0]   bcpu_q, bcpu_d, bbus_q, bbus_d;
  logic                full_q, full_d;
  logic [TAG_W-1:0]    nid_q, nid_d;
  crt_pkg::crt_out_t   res_q, res_d;

  logic [SUM_W-1:0]    sum;
  logic [CNT_W-1:0]    jnext;
  logic [FREQ_W-1:0]   win_cpu, win_bus, new_cpu, new_bus;

  assign sum   = {1'b0, mem_rdata.cpu} + {1'b0, mem_rdata.bus};
  assign jnext = CNT_W'(fidx_q) + CNT_W'(1);

  // Winner is zeroed when every sum was zero, then lifted to the floors.
  assign win_cpu = (bsum_q != '0) ? bcpu_q : '0;
  assign win_bus = (bsum_q != '0) ? bbus_q : '0;
  assign new_cpu = (win_cpu < cfg.floor_cpu) ? cfg.floor_cpu : win_cpu;
  assign new_bus = (win_bus < cfg.floor_bus) ? cfg.floor_bus : win_bus;

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    cur_cpu_d = cur_cpu_q;
    cur_bus_d = cur_bus_q;
    done_d    = 1'b0;
    pv_d      = pv_q;
    phase_d   = phase_q;
    rcpu_d    = rcpu_q;
    rbus_d    = rbus_q;
    lid_d     = lid_q;
    ptr_d     = ptr_q;
    pidx_d    = pidx_q;
    used_d    = used_q;
    idc_d     = idc_q;
    found_d   = found_q;
    fidx_d    = fidx_q;
    any_d     = any_q;
    bsum_d    = bsum_q;
    bcpu_d    = bcpu_q;
    bbus_d    = bbus_q;
    full_d    = full_q;
    nid_d     = nid_q;
    res_d     = res_q;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          rcpu_d  = req_i.req_cpu;
          rbus_d  = req_i.req_bus;
          lid_d   = req_i.leave_id;
          nid_d   = '0;
          full_d  = 1'b0;
          ptr_d   = '0;
          pv_d    = 1'b0;
          used_d  = '0;
          found_d = 1'b0;
          any_d   = 1'b0;
          state_d = S_SCAN;
          if (req_i.cmd == crt_pkg::CMD_HOT) begin
            rcpu_d = req_i.music_playing ? cfg.music_cpu : cfg.hot_cpu;
            rbus_d = req_i.music_playing ? cfg.music_bus : cfg.hot_bus;
          end
          case (req_i.cmd) inside
            crt_pkg::CMD_ENTER, crt_pkg::CMD_HOT: begin
              phase_d = PH_USED;
              if (count_q == CNT_W'(TABLE_DEPTH)) begin
                full_d  = 1'b1;
                state_d = S_APPLY;
              end
            end
            crt_pkg::CMD_LEAVE: phase_d = PH_FIND;
            default:            phase_d = PH_MAX;
          endcase
        end
      end

      S_SCAN: begin
        // Reads are pipelined: the beat read last cycle is folded in now.
        if (pv_q) begin
          case (phase_q)
            PH_USED: used_d = used_q | ({{(NT-1){1'b0}}, 1'b1} << mem_rdata.tag);
            PH_FIND: begin
              if (!found_q && mem_rdata.tag == lid_q) begin
                found_d = 1'b1;
                fidx_d  = pidx_q;
              end
            end
            PH_MAX: begin
              if (!any_q || sum > bsum_q) begin
                any_d  = 1'b1;
                bsum_d = sum;
                bcpu_d = mem_rdata.cpu;
                bbus_d = mem_rdata.bus;
              end
            end
            default: ;
          endcase
        end
        if (ptr_q < count_q) begin
          mem_re    = 1'b1;
          mem_raddr = ptr_q[IDX_W-1:0];
          pidx_d    = ptr_q[IDX_W-1:0];
          ptr_d     = ptr_q + CNT_W'(1);
          pv_d      = 1'b1;
        end else begin
          pv_d = 1'b0;
          if (!pv_q) begin
            case (phase_q)
              PH_USED: begin
                idc_d   = '0;
                state_d = S_FREE;
              end
              PH_FIND: begin
                if (found_q) begin
                  state_d = S_SHRD;
                end else begin
                  phase_d = PH_MAX;
                  ptr_d   = '0;
                  any_d   = 1'b0;
                end
              end
              default: state_d = S_APPLY;
            endcase
          end
        end
      end

      S_FREE: begin
        if (!used_q[idc_q]) begin
          mem_we        = 1'b1;
          mem_waddr     = count_q[IDX_W-1:0];
          mem_wdata.tag = idc_q;
          mem_wdata.cpu = rcpu_q;
          mem_wdata.bus = rbus_q;
          count_d       = count_q + CNT_W'(1);
          nid_d         = idc_q;
          phase_d       = PH_MAX;
          ptr_d         = '0;
          any_d         = 1'b0;
          state_d       = S_SCAN;
        end else if (idc_q == TAG_W'(NT - 1)) begin
          // Every id is taken: treated as a full table.
          full_d  = 1'b1;
          state_d = S_APPLY;
        end else begin
          idc_d = idc_q + TAG_W'(1);
        end
      end

      S_SHRD: begin
        if (jnext < count_q) begin
          mem_re    = 1'b1;
          mem_raddr = jnext[IDX_W-1:0];
          state_d   = S_SHWR;
        end else begin
          count_d = count_q - CNT_W'(1);
          phase_d = PH_MAX;
          ptr_d   = '0;
          any_d   = 1'b0;
          state_d = S_SCAN;
        end
      end

      S_SHWR: begin
        mem_we    = 1'b1;
        mem_waddr = fidx_q;
        mem_wdata = mem_rdata;
        fidx_d    = jnext[IDX_W-1:0];
        state_d   = S_SHRD;
      end

      S_APPLY: begin
        res_d.status        = full_q;
        res_d.new_id        = nid_q;
        res_d.clock_changed = 1'b0;
        if (!full_q && count_q != '0 &&
            (new_cpu != cur_cpu_q || new_bus != cur_bus_q)) begin
          cur_cpu_d           = new_cpu;
          cur_bus_d           = new_bus;
          res_d.clock_changed = 1'b1;
        end
        res_d.cpu_out = cur_cpu_d;
        res_d.bus_out = cur_bus_d;
        done_d        = 1'b1;
        state_d       = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      cur_cpu_q <= '0;
      cur_bus_q <= '0;
      done_q    <= 1'b0;
      pv_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      cur_cpu_q <= cur_cpu_d;
      cur_bus_q <= cur_bus_d;
      done_q    <= done_d;
      pv_q      <= pv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    phase_q <= phase_d;
    rcpu_q  <= rcpu_d;
    rbus_q  <= rbus_d;
    lid_q   <= lid_d;
    ptr_q   <= ptr_d;
    pidx_q  <= pidx_d;
    used_q  <= used_d;
    idc_q   <= idc_d;
    found_q <= found_d;
    fidx_q  <= fidx_d;
    any_q   <= any_d;
    bsum_q  <= bsum_d;
    bcpu_q  <= bcpu_d;
    bbus_q  <= bbus_d;
    full_q  <= full_d;
    nid_q   <= nid_d;
    res_q   <= res_d;
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

  `CRT_ASSERT(a_done_idle, clk_i, rst_ni, done_o |-> !busy)
  `CRT_ASSERT(a_count_range, clk_i, rst_ni, count_q <= CNT_W'(TABLE_DEPTH))
  `CRT_ASSERT(a_start_busy, clk_i, rst_ni, (start && !busy) |=> (busy && !done_o))
  `CRT_ASSERT_NR(a_reset_quiet, clk_i, (!rst_ni) |=> (!done_o && !busy))

endmodule

// ===== tb/clock_request_table_test.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Clock request table testbench
// Drives enter, enter-hot, leave and recompute commands through the start/busy
// handshake, predicts every result beat from a behavioural copy of the table,
// and compares the beats field by field across several register settings.
// ---------------------------------------------------------------------------
module clock_request_table_test;
  import crt_pkg::*;

  localparam int DEPTH       = TABLE_DEPTH_DEF;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 230;
  localparam int SETTLE      = 100;
  localparam int MAX_REPORTS = 10;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  crt_in_t              req_drv;
  logic                 done;
  crt_out_t             res_obs;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [FREQ_W-1:0]    cfg_data;

  clock_request_table uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_drv),
    .done_o     (done),
    .res_o      (res_obs),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Behavioural copy of the table, the clocks and the registers.
  logic [FREQ_W-1:0] tbl_cpu [DEPTH];
  logic [FREQ_W-1:0] tbl_bus [DEPTH];
  logic [TAG_W-1:0]  tbl_tag [DEPTH];
  int                tbl_count;
  logic [FREQ_W-1:0] cur_cpu, cur_bus;
  logic [FREQ_W-1:0] min_cpu, min_bus, hot_cpu, hot_bus, mus_cpu, mus_bus;

  crt_in_t  pending_q [$];
  crt_out_t clocks_q [$];

  int  errors;
  int  n_by_cmd [4];
  int  n_full, n_changed, peak_count, n_settings;
  bit  idle_ok;
  bit  fill_mode;
  int  gap_left;

  function automatic void store_register(crt_cfg_idx_e idx, logic [FREQ_W-1:0] v);
    case (idx)
      CFG_FLOOR_CPU: min_cpu = v;
      CFG_FLOOR_BUS: min_bus = v;
      CFG_HOT_CPU:   hot_cpu = v;
      CFG_HOT_BUS:   hot_bus = v;
      CFG_MUSIC_CPU: mus_cpu = v;
      CFG_MUSIC_BUS: mus_bus = v;
      default: ;
    endcase
  endfunction

  // Picks the first entry with the greatest sum, applies the floors and
  // returns 1 when the clocks move. An empty table leaves the clocks alone.
  function automatic logic refresh_clocks();
    int                best;
    logic [FREQ_W:0]   top, sum;
    logic [FREQ_W-1:0] c, b;
    if (tbl_count == 0) return 1'b0;
    best = 0;
    top  = {1'b0, tbl_cpu[0]} + {1'b0, tbl_bus[0]};
    for (int i = 1; i < tbl_count; i++) begin
      sum = {1'b0, tbl_cpu[i]} + {1'b0, tbl_bus[i]};
      if (sum > top) begin
        top  = sum;
        best = i;
      end
    end
    c = '0;
    b = '0;
    if (top != 0) begin
      c = tbl_cpu[best];
      b = tbl_bus[best];
    end
    if (c < min_cpu) c = min_cpu;
    if (b < min_bus) b = min_bus;
    if (c != cur_cpu || b != cur_bus) begin
      cur_cpu = c;
      cur_bus = b;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic crt_out_t clock_step(crt_in_t it);
    crt_out_t          r;
    int                slot;
    int                hit;
    logic [NUM_TAGS-1:0] used;
    logic [FREQ_W-1:0] pc, pb;
    r = '0;
    n_by_cmd[it.cmd]++;
    case (it.cmd)
      CMD_ENTER, CMD_HOT: begin
        slot = -1;
        if (tbl_count < DEPTH) begin
          used = '0;
          for (int i = 0; i < tbl_count; i++) used[tbl_tag[i]] = 1'b1;
          for (int id = 0; id < NUM_TAGS; id++)
            if (slot < 0 && !used[id]) slot = id;
        end
        pc = it.req_cpu;
        pb = it.req_bus;
        if (it.cmd == CMD_HOT) begin
          pc = it.music_playing ? mus_cpu : hot_cpu;
          pb = it.music_playing ? mus_bus : hot_bus;
        end
        if (slot < 0) begin
          r.status = 1'b1;
          n_full++;
        end else begin
          tbl_cpu[tbl_count] = pc;
          tbl_bus[tbl_count] = pb;
          tbl_tag[tbl_count] = slot[TAG_W-1:0];
          tbl_count++;
          if (tbl_count > peak_count) peak_count = tbl_count;
          r.new_id        = slot[TAG_W-1:0];
          r.clock_changed = refresh_clocks();
        end
      end
      CMD_LEAVE: begin
        hit = -1;
        for (int i = 0; i < tbl_count; i++)
          if (hit < 0 && tbl_tag[i] == it.leave_id) hit = i;
        if (hit >= 0) begin
          for (int j = hit; j < tbl_count - 1; j++) begin
            tbl_cpu[j] = tbl_cpu[j+1];
            tbl_bus[j] = tbl_bus[j+1];
            tbl_tag[j] = tbl_tag[j+1];
          end
          tbl_count--;
        end
        r.clock_changed = refresh_clocks();
      end
      default: r.clock_changed = refresh_clocks();
    endcase
    r.cpu_out = cur_cpu;
    r.bus_out = cur_bus;
    if (r.clock_changed) n_changed++;
    return r;
  endfunction

  function automatic logic [FREQ_W-1:0] pick_freq();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return FREQ_W'($urandom_range(0, 3));
      3:       return FREQ_W'($urandom_range(100, 400));
      default: return FREQ_W'($urandom_range(0, 1023));
    endcase
  endfunction

  function automatic crt_in_t make_cmd(crt_cmd_e c, int cpu, int bus, int id, bit music);
    crt_in_t it;
    it.cmd           = c;
    it.req_cpu       = FREQ_W'(cpu);
    it.req_bus       = FREQ_W'(bus);
    it.leave_id      = TAG_W'(id);
    it.music_playing = music;
    return it;
  endfunction

  // Mostly fill-then-drain sweeps, so the table reaches full and empty often;
  // leaves usually name an id that is present. A tenth of commands are noise.
  function automatic crt_in_t next_command();
    crt_in_t it;
    int      roll, k;
    it.req_cpu       = pick_freq();
    it.req_bus       = pick_freq();
    it.leave_id      = TAG_W'($urandom_range(0, 15));
    it.music_playing = 1'($urandom_range(0, 1));
    if (tbl_count == DEPTH && $urandom_range(0, 2) == 0) fill_mode = 1'b0;
    if (tbl_count == 0 && $urandom_range(0, 1) == 0) fill_mode = 1'b1;
    roll = $urandom_range(0, 99);
    if (roll < 10) begin
      it.cmd = crt_cmd_e'($urandom_range(0, 3));
      return it;
    end
    if (fill_mode) begin
      if (roll < 62)      it.cmd = CMD_ENTER;
      else if (roll < 80) it.cmd = CMD_HOT;
      else if (roll < 92) it.cmd = CMD_LEAVE;
      else                it.cmd = CMD_RECOMP;
    end else begin
      if (roll < 70)      it.cmd = CMD_LEAVE;
      else if (roll < 80) it.cmd = CMD_ENTER;
      else if (roll < 88) it.cmd = CMD_HOT;
      else                it.cmd = CMD_RECOMP;
    end
    if (tbl_count > 0) begin
      k = $urandom_range(0, tbl_count - 1);
      if (it.cmd == CMD_LEAVE && $urandom_range(0, 9) != 0) it.leave_id = tbl_tag[k];
      // Same sum as an existing entry, to exercise the first-wins tie rule.
      if (it.cmd == CMD_ENTER && $urandom_range(0, 7) == 0) begin
        it.req_cpu = tbl_bus[k];
        it.req_bus = tbl_cpu[k];
      end
    end
    return it;
  endfunction

  task automatic write_one(crt_cfg_idx_e idx, logic [FREQ_W-1:0] v);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= v;
    store_register(idx, v);
  endtask

  task automatic program_registers(logic [FREQ_W-1:0] fc, fb, hc, hb, mc, mb);
    write_one(CFG_FLOOR_CPU, fc);
    write_one(CFG_FLOOR_BUS, fb);
    write_one(CFG_HOT_CPU, hc);
    write_one(CFG_HOT_BUS, hb);
    write_one(CFG_MUSIC_CPU, mc);
    write_one(CFG_MUSIC_BUS, mb);
    @(posedge clk_i);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  task automatic wait_quiet();
    do @(negedge clk_i);
    while (pending_q.size() != 0 || clocks_q.size() != 0 || busy || start);
  endtask

  task automatic report(string what);
    errors++;
    if (errors <= MAX_REPORTS) $display("ERROR at %0t: %s", $realtime, what);
  endtask

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) report($sformatf("%s expected %0d, got %0d", name, want, got));
  endtask

  // Driver: a command beat is taken at an edge where start is high and busy low.
  always @(posedge clk_i) begin : drive_proc
    crt_in_t taken;
    if (!rst_ni) begin
      start    <= 1'b0;
      gap_left = 0;
    end else begin
      if (start && !busy) begin
        taken = pending_q.pop_front();
        clocks_q.push_back(clock_step(taken));
      end
      if (gap_left > 0) begin
        start <= 1'b0;
        gap_left--;
      end else if (pending_q.size() == 0) begin
        start <= 1'b0;
      end else if (idle_ok && $urandom_range(0, (start && busy) ? 15 : 2) == 0) begin
        start    <= 1'b0;
        gap_left = $urandom_range(0, 4);
      end else begin
        start   <= 1'b1;
        req_drv <= pending_q[0];
      end
    end
  end

  // Monitor: every result beat is checked against the oldest prediction.
  always @(posedge clk_i) begin : watch_proc
    crt_out_t want;
    if (rst_ni && done) begin
      if (clocks_q.size() == 0) begin
        report("result beat with no command outstanding");
      end else begin
        want = clocks_q.pop_front();
        check_field("status", 32'(want.status), 32'(res_obs.status));
        check_field("new_id", 32'(want.new_id), 32'(res_obs.new_id));
        check_field("cpu_out", 32'(want.cpu_out), 32'(res_obs.cpu_out));
        check_field("bus_out", 32'(want.bus_out), 32'(res_obs.bus_out));
        check_field("clock_changed", 32'(want.clock_changed),
                    32'(res_obs.clock_changed));
      end
    end
  end

  initial begin
    #15ms;
    $display("Timeout: %0d results still awaited", clocks_q.size());
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    clk_i    = 1'b0;
    rst_ni   = 1'b0;
    cfg_we   = 1'b0;
    cfg_idx  = CFG_FLOOR_CPU;
    cfg_data = '0;
    errors   = 0;
    n_full   = 0;
    n_changed = 0;
    peak_count = 0;
    n_settings = 0;
    idle_ok  = 1'b1;
    fill_mode = 1'b1;
    foreach (n_by_cmd[i]) n_by_cmd[i] = 0;
    tbl_count = 0;
    cur_cpu  = '0;
    cur_bus  = '0;
    min_cpu  = FLOOR_CPU_RST;
    min_bus  = FLOOR_BUS_RST;
    hot_cpu  = HOT_CPU_RST;
    hot_bus  = HOT_BUS_RST;
    mus_cpu  = MUSIC_CPU_RST;
    mus_bus  = MUSIC_BUS_RST;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    program_registers(FLOOR_CPU_RST, FLOOR_BUS_RST, HOT_CPU_RST, HOT_BUS_RST,
                      MUSIC_CPU_RST, MUSIC_BUS_RST);

    // Directed: empty table, zero sums, extremes, both presets, gap closing,
    // unknown ids, id reuse, ties, a full table and both rejected enters.
    pending_q.push_back(make_cmd(CMD_RECOMP, 0, 0, 0, 1'b0));
    pending_q.push_back(make_cmd(CMD_LEAVE, 1023, 1023, 7, 1'b1));
    pending_q.push_back(make_cmd(CMD_ENTER, 0, 0, 0, 1'b0));
    pending_q.push_back(make_cmd(CMD_ENTER, 1023, 1023, 15, 1'b1));
    pending_q.push_back(make_cmd(CMD_HOT, 0, 0, 0, 1'b0));
    pending_q.push_back(make_cmd(CMD_HOT, 0, 0, 0, 1'b1));
    pending_q.push_back(make_cmd(CMD_LEAVE, 0, 0, 1, 1'b0));
    pending_q.push_back(make_cmd(CMD_LEAVE, 0, 0, 15, 1'b0));
    pending_q.push_back(make_cmd(CMD_ENTER, 1023, 0, 0, 1'b0));
    pending_q.push_back(make_cmd(CMD_ENTER, 0, 1023, 0, 1'b0));
    for (int i = 0; i < 11; i++)
      pending_q.push_back(make_cmd(CMD_ENTER, int'(pick_freq()), int'(pick_freq()), 0, 1'b0));
    pending_q.push_back(make_cmd(CMD_ENTER, 500, 500, 0, 1'b0));
    pending_q.push_back(make_cmd(CMD_HOT, 0, 0, 0, 1'b1));
    pending_q.push_back(make_cmd(CMD_LEAVE, 0, 0, 0, 1'b0));
    pending_q.push_back(make_cmd(CMD_LEAVE, 0, 0, 9, 1'b1));
    wait_quiet();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: program_registers('0, '0, '0, '0, '0, '0);
        1: program_registers('1, '1, '1, '1, '1, '1);
        2: program_registers(FREQ_W'($urandom_range(0, 7)), FREQ_W'($urandom_range(0, 7)),
                             '1, '0, '0, '1);
        default: program_registers(FREQ_W'($urandom_range(0, 1023)),
                                   FREQ_W'($urandom_range(0, 1023)),
                                   FREQ_W'($urandom_range(0, 1023)),
                                   FREQ_W'($urandom_range(0, 1023)),
                                   FREQ_W'($urandom_range(0, 1023)),
                                   FREQ_W'($urandom_range(0, 1023)));
      endcase
      // One phase in the middle and the closing one run back to back.
      idle_ok = (p != 3 && p != PHASES - 1);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        while (pending_q.size() != 0) @(negedge clk_i);
        pending_q.push_back(next_command());
      end
      wait_quiet();
    end

    repeat (SETTLE) @(posedge clk_i);
    if (clocks_q.size() != 0) report($sformatf("%0d results never arrived", clocks_q.size()));
    $display("Commands: %0d enter, %0d enter-hot, %0d leave, %0d recompute over %0d settings.",
             n_by_cmd[CMD_ENTER], n_by_cmd[CMD_HOT], n_by_cmd[CMD_LEAVE],
             n_by_cmd[CMD_RECOMP], n_settings);
    $display("Table peaked at %0d entries; %0d enters refused as full, %0d clock changes.",
             peak_count, n_full, n_changed);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches in total", errors);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
